FILE: rtl/thac_pkg.sv
// ----------------------------------------------------------------------------
// thac_pkg: shared types and constants for the thermistor converter
// Status codes, register indexes, field widths and the per-word tag.
// ----------------------------------------------------------------------------
package thac_pkg;

  localparam int MV_W    = 16;
  localparam int R_W     = 24;
  localparam int COEF_W  = 32;
  localparam int CONST_W = 24;
  localparam int TEMP_W  = 16;
  localparam int NUM_W   = MV_W + R_W;         // divider numerator
  localparam int PROD_W  = COEF_W + R_W + 1;   // coeff times 24-bit unsigned
  localparam int SUM_W   = 81;                 // |S| < 2^80

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DENOM = 2'd2;

  typedef enum logic [2:0] {
    REG_FS    = 3'd0,
    REG_DIV   = 3'd1,
    REG_SUP   = 3'd2,
    REG_QUAD  = 3'd3,
    REG_LIN   = 3'd4,
    REG_CONST = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] ch;
    logic [1:0] status;
    logic       sat;
  } tag_t;

endpackage

FILE: rtl/thermistor_adc_to_celsius.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius: ADC code to Q8.8 degrees Celsius
// Fully pipelined conversion: code to mV, divider resistance, quadratic fit.
// ----------------------------------------------------------------------------
// One word enters per clock and one result word leaves per clock while the
// output is not stalled. The stages, in order: four stages scale the code to
// millivolts (a division by the ADC full scale done as folds of the code
// bits), one stage forms the divider numerator, twelve stages resolve the
// 24-bit resistance two quotient bits each, six stages evaluate the quadratic
// with a multiplier in each of the first four, and the output register. A
// two-entry output buffer (output register and skid word) lets the input
// keep flowing after the output stalls until the skid word fills; the whole
// pipeline then freezes with nothing lost. Codes of zero or full scale report
// status 1, a non-positive divider denominator reports status 2, both with a
// zero temperature. Registers sit on an APB-style port at byte address 4*index.
module thermistor_adc_to_celsius
  import thac_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADC_BITS-1:0]       in_adc_code,
  input  logic [1:0]                in_channel,
  // result words
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_channel_out,
  output logic signed [TEMP_W-1:0]  out_temperature,
  output logic [1:0]                out_status,
  output logic                      out_saturated,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int PW = ADC_BITS + MV_W;                   // code * mV
  localparam int RW = MV_W + 2;                          // fold remainder
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}}; // 2^B - 1
  localparam int DIV_STEPS = 2;                          // quotient bits/stage
  localparam int DIV_ST = R_W / DIV_STEPS;
  // stage map: 0..3 mV scaling, 4 numerator, 5.. divider, then polynomial
  localparam int ST_NUM = 4;
  localparam int ST_DV0 = 5;
  localparam int ST_P1  = ST_DV0 + DIV_ST;
  localparam int NST    = ST_P1 + 6;
  localparam logic signed [SUM_W-1:0] ROUND_C = 81'sd2147483648;
  localparam logic signed [48:0] T_MAX = 49'sd32767;
  localparam logic signed [48:0] T_MIN = -49'sd32768;

  // ---------------- configuration registers ----------------
  logic [MV_W-1:0]           fs_mv_r, sup_r;
  logic [R_W-1:0]            div_r;
  logic signed [COEF_W-1:0]  quad_r, lin_r;
  logic signed [CONST_W-1:0] cst_r;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_mv_r <= 16'd3300;
      div_r   <= 24'd10000;
      sup_r   <= 16'd3300;
      quad_r  <= 32'sd607874;
      lin_r   <= -32'sd168198;
      cst_r   <= 24'sd11219;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_FS:    fs_mv_r <= pwdata[MV_W-1:0];
        REG_DIV:   div_r   <= pwdata[R_W-1:0];
        REG_SUP:   sup_r   <= pwdata[MV_W-1:0];
        REG_QUAD:  quad_r  <= $signed(pwdata);
        REG_LIN:   lin_r   <= $signed(pwdata);
        REG_CONST: cst_r   <= $signed(pwdata[CONST_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FS:    prdata = {16'd0, fs_mv_r};
      REG_DIV:   prdata = {8'd0, div_r};
      REG_SUP:   prdata = {16'd0, sup_r};
      REG_QUAD:  prdata = quad_r;
      REG_LIN:   prdata = lin_r;
      REG_CONST: prdata = {8'd0, cst_r};
      default:   prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // One enable for all stages; it drops only when the output buffer is full.
  logic             en;
  logic [NST-1:0]   vld_r;
  tag_t             tag_r  [NST];
  tag_t             tag_in [NST];
  logic             sk_vld_r;

  assign en       = !sk_vld_r;
  assign in_ready = en;

  // ---------------- stage payloads ----------------
  logic [PW-1:0]       p1_r;
  logic [MV_W-1:0]     q2_r, q3_r, v4_r;
  logic [RW-1:0]       r2_r, r3_r;
  logic [NUM_W-1:0]    num5_r;
  logic [MV_W-1:0]     den5_r;
  logic                dv0_sat;

  // fold step values
  logic [MV_W-1:0]     q3_nxt, v4_nxt;
  logic [RW-1:0]       r2_nxt, r3_nxt, rf;

  assign r2_nxt = RW'(p1_r[PW-1:ADC_BITS]) + RW'(p1_r[ADC_BITS-1:0]);
  assign q3_nxt = q2_r + MV_W'(r2_r >> ADC_BITS);
  assign r3_nxt = RW'(r2_r >> ADC_BITS) + RW'(r2_r[ADC_BITS-1:0]);
  // last fold leaves a remainder below twice the full scale
  assign rf     = RW'(r3_r >> ADC_BITS) + RW'(r3_r[ADC_BITS-1:0]);
  assign v4_nxt = q3_r + MV_W'(r3_r >> ADC_BITS) + MV_W'(rf >= RW'(FS));

  // resistance clamps when the quotient would reach 2^24
  assign dv0_sat = num5_r[NUM_W-1:R_W] >= den5_r;

  // tag entering each stage
  always_comb begin
    tag_in[0].ch     = in_channel;
    tag_in[0].status = (in_adc_code == '0 || in_adc_code >= FS) ? ST_RANGE : ST_OK;
    tag_in[0].sat    = 1'b0;
    for (int k = 1; k < NST; k++) begin
      tag_in[k] = tag_r[k-1];
    end
    if (tag_r[ST_NUM-1].status == ST_OK && v4_r >= sup_r) begin
      tag_in[ST_NUM].status = ST_DENOM;
    end
    tag_in[ST_DV0].sat = (tag_r[ST_NUM].status == ST_OK) && dv0_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        tag_r[k] <= tag_in[k];
      end
      p1_r   <= PW'(in_adc_code) * PW'(fs_mv_r);
      q2_r   <= p1_r[PW-1:ADC_BITS];
      r2_r   <= r2_nxt;
      q3_r   <= q3_nxt;
      r3_r   <= r3_nxt;
      v4_r   <= v4_nxt;
      num5_r <= NUM_W'(div_r) * NUM_W'(v4_r);
      den5_r <= sup_r - v4_r;
    end
  end

  // ---------------- restoring divider, two bits per stage ----------------
  logic [MV_W-1:0] dv_rem_r [DIV_ST];
  logic [R_W-1:0]  dv_low_r [DIV_ST];
  logic [R_W-1:0]  dv_q_r   [DIV_ST];
  logic [MV_W-1:0] dv_den_r [DIV_ST];
  logic [MV_W-1:0] dv_rem_i [DIV_ST];
  logic [R_W-1:0]  dv_low_i [DIV_ST];
  logic [R_W-1:0]  dv_q_i   [DIV_ST];
  logic [MV_W-1:0] dv_den_i [DIV_ST];

  assign dv_rem_i[0] = num5_r[NUM_W-1:R_W];
  assign dv_low_i[0] = num5_r[R_W-1:0];
  assign dv_q_i[0]   = '0;
  assign dv_den_i[0] = den5_r;

  genvar g;
  generate
    for (g = 1; g < DIV_ST; g++) begin : g_dv_link
      assign dv_rem_i[g] = dv_rem_r[g-1];
      assign dv_low_i[g] = dv_low_r[g-1];
      assign dv_q_i[g]   = dv_q_r[g-1];
      assign dv_den_i[g] = dv_den_r[g-1];
    end

    for (g = 0; g < DIV_ST; g++) begin : g_dv
      logic [MV_W-1:0] rem;
      logic [R_W-1:0]  low, q;
      logic [MV_W:0]   rem2;

      always_comb begin
        rem = dv_rem_i[g];
        low = dv_low_i[g];
        q   = dv_q_i[g];
        rem2 = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
          rem2 = {rem, low[R_W-1]};
          low  = {low[R_W-2:0], 1'b0};
          if (rem2 >= {1'b0, dv_den_i[g]}) begin
            rem = MV_W'(rem2 - {1'b0, dv_den_i[g]});
            q   = {q[R_W-2:0], 1'b1};
          end else begin
            rem = rem2[MV_W-1:0];
            q   = {q[R_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[g] <= rem;
          dv_low_r[g] <= low;
          dv_q_r[g]   <= q;
          dv_den_r[g] <= dv_den_i[g];
        end
      end
    end
  endgenerate

  // ---------------- quadratic ----------------
  logic [R_W-1:0]             p1r_r, p2r_r, p3r_r;
  logic [2*R_W-1:0]           p1sq_r;
  logic [R_W-1:0]             p2hi_r;
  logic signed [PROD_W-1:0]   p2pa_r, p3pa_r, p3pb_r, p4pa_r, p4pb_r, p4lr_r, p5lr_r;
  logic signed [SUM_W-1:0]    p5s1_r, p6s_r;
  logic [R_W-1:0]             r_sel;

  assign r_sel = tag_r[ST_P1-1].sat ? {R_W{1'b1}} : dv_q_r[DIV_ST-1];

  always_ff @(posedge clk) begin
    if (en) begin
      p1r_r  <= r_sel;
      p1sq_r <= (2*R_W)'(r_sel) * (2*R_W)'(r_sel);
      p2r_r  <= p1r_r;
      p2hi_r <= p1sq_r[2*R_W-1:R_W];
      p2pa_r <= quad_r * $signed({1'b0, p1sq_r[R_W-1:0]});
      p3r_r  <= p2r_r;
      p3pa_r <= p2pa_r;
      p3pb_r <= quad_r * $signed({1'b0, p2hi_r});
      p4pa_r <= p3pa_r;
      p4pb_r <= p3pb_r;
      p4lr_r <= lin_r * $signed({1'b0, p3r_r});
      p5s1_r <= (SUM_W'(p4pb_r) <<< R_W) + SUM_W'(p4pa_r);
      p5lr_r <= p4lr_r;
      p6s_r  <= p5s1_r + (SUM_W'(p5lr_r) <<< 16) + (SUM_W'(cst_r) <<< 32) + ROUND_C;
    end
  end

  // ---------------- rounding, saturation, status ----------------
  logic signed [48:0]       t_full;
  logic signed [TEMP_W-1:0] t_res;
  logic                     t_sat;
  tag_t                     t_last;
  logic [1:0]               res_ch, res_st;
  logic signed [TEMP_W-1:0] res_temp;
  logic                     res_sat;

  assign t_full = p6s_r[SUM_W-1:32];
  assign t_last = tag_r[NST-1];

  always_comb begin
    t_sat = 1'b1;
    if (t_full > T_MAX) begin
      t_res = 16'sh7FFF;
    end else if (t_full < T_MIN) begin
      t_res = -16'sd32768;
    end else begin
      t_res = t_full[TEMP_W-1:0];
      t_sat = 1'b0;
    end
    res_ch = t_last.ch;
    res_st = t_last.status;
    if (t_last.status == ST_OK) begin
      res_temp = t_res;
      res_sat  = t_last.sat | t_sat;
    end else begin
      res_temp = '0;
      res_sat  = 1'b0;
    end
  end

  // ---------------- output register and skid word ----------------
  logic                     out_vld_r;
  logic [1:0]               o_ch_r, o_st_r, sk_ch_r, sk_st_r;
  logic signed [TEMP_W-1:0] o_t_r, sk_t_r;
  logic                     o_sat_r, sk_sat_r;
  logic                     push;

  assign push = en & vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (sk_vld_r) begin
      if (out_ready) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= push;
    end else if (push) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_vld_r) begin
      if (out_ready) begin
        o_ch_r  <= sk_ch_r;
        o_st_r  <= sk_st_r;
        o_t_r   <= sk_t_r;
        o_sat_r <= sk_sat_r;
      end
    end else if (!out_vld_r || out_ready) begin
      o_ch_r  <= res_ch;
      o_st_r  <= res_st;
      o_t_r   <= res_temp;
      o_sat_r <= res_sat;
    end else begin
      sk_ch_r  <= res_ch;
      sk_st_r  <= res_st;
      sk_t_r   <= res_temp;
      sk_sat_r <= res_sat;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_channel_out = o_ch_r;
  assign out_temperature = o_t_r;
  assign out_status      = o_st_r;
  assign out_saturated   = o_sat_r;

endmodule

FILE: bench/thac_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thac_checker: result predictor and scoreboard for the thermistor converter
// Mirrors the register file from APB writes, predicts one temperature word
// per accepted input word and compares each accepted result in order.
// ----------------------------------------------------------------------------
module thac_checker
  import thac_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [11:0]              in_adc_code,
  input  logic [1:0]               in_channel,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               out_channel_out,
  input  logic signed [TEMP_W-1:0] out_temperature,
  input  logic [1:0]               out_status,
  input  logic                     out_saturated,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [1:0]  ch;
    logic [15:0] temp;
    logic [1:0]  status;
    logic        sat;
  } temp_word_t;

  temp_word_t temps_due[$];

  logic [15:0] fs_mv, sup_mv;
  logic [23:0] div_ohms;
  logic signed [31:0] quad_c, lin_c;
  logic signed [23:0] const_c;

  assign pending = temps_due.size();

  function automatic temp_word_t convert(logic [11:0] code, logic [1:0] ch);
    temp_word_t w;
    logic [63:0] v, r;
    logic signed [95:0] s, t;
    w.ch = ch;
    w.temp = '0;
    w.sat = 1'b0;
    w.status = ST_OK;
    if (code == 0 || code >= 12'hFFF) begin
      w.status = ST_RANGE;
      return w;
    end
    v = (64'(code) * 64'(fs_mv)) / 64'd4095;
    if (v >= 64'(sup_mv)) begin
      w.status = ST_DENOM;
      return w;
    end
    r = (64'(div_ohms) * v) / (64'(sup_mv) - v);
    if (r > 64'hFF_FFFF) begin
      r = 64'hFF_FFFF;
      w.sat = 1'b1;
    end
    s = 96'(quad_c) * $signed({1'b0, r * r}) + (96'(lin_c) * $signed({1'b0, r}) <<< 16)
      + (96'(const_c) <<< 32) + (96'sd1 <<< 31);
    t = s >>> 32;
    if (t > 32767) begin
      t = 32767;
      w.sat = 1'b1;
    end else if (t < -32768) begin
      t = -32768;
      w.sat = 1'b1;
    end
    w.temp = t[15:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    temp_word_t w;
    if (!rst_n) begin
      fs_mv <= 16'd3300;
      div_ohms <= 24'd10000;
      sup_mv <= 16'd3300;
      quad_c <= 32'sd607874;
      lin_c <= -32'sd168198;
      const_c <= 24'sd11219;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_FS:    fs_mv <= pwdata[15:0];
          REG_DIV:   div_ohms <= pwdata[23:0];
          REG_SUP:   sup_mv <= pwdata[15:0];
          REG_QUAD:  quad_c <= pwdata;
          REG_LIN:   lin_c <= pwdata;
          REG_CONST: const_c <= pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) temps_due.push_back(convert(in_adc_code, in_channel));
      if (out_valid && out_ready) begin
        if (temps_due.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = temps_due.pop_front();
          if (out_channel_out !== w.ch) report_mismatch("channel", out_channel_out, w.ch);
          if (out_temperature !== w.temp)
            report_mismatch("temperature", out_temperature, $signed(w.temp));
          if (out_status !== w.status) report_mismatch("status", out_status, w.status);
          if (out_saturated !== w.sat) report_mismatch("saturated", out_saturated, w.sat);
        end
      end
    end
  end

endmodule

FILE: bench/thermistor_adc_to_celsius_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius_tb: stimulus and verdict for the converter
// Runs directed and random code words over several register settings, with
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module thermistor_adc_to_celsius_tb;
  import thac_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [11:0] in_adc_code;
  logic [1:0] in_channel;
  logic out_valid, out_ready;
  logic [1:0] out_channel_out, out_status;
  logic signed [TEMP_W-1:0] out_temperature;
  logic out_saturated;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending;
  bit calm;        // stretch with no idling on either side
  bit hold_off;    // long output stall in progress

  thermistor_adc_to_celsius uut (.*);

  thac_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off driven from the stimulus side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 29);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one word; valid stays up across back-to-back words
  task automatic send_word(logic [11:0] code, logic [1:0] ch);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_adc_code <= code;
    in_channel <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);  // well past the pipeline depth
  endtask

  // mostly random codes over the full range, with edges now and then
  function automatic logic [11:0] pick_code();
    case ($urandom_range(9))
      0: return 12'($urandom_range(3));
      1: return 12'($urandom_range(4095, 4092));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_words(int n);
    repeat (n) send_word(pick_code(), 2'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_code = '0;
    in_channel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed, reset coefficients: range rejects, extremes, every channel
    send_word(12'd0, 2'd0);
    send_word(12'd4095, 2'd3);
    send_word(12'd4094, 2'd1);
    send_word(12'd1, 2'd2);
    send_word(12'd2048, 2'd3);
    send_word(12'hAAA, 2'd0);
    send_word(12'h555, 2'd1);
    drain();

    // zero-ohm divider, supply zero gives denominator faults
    write_reg(REG_DIV, 32'd0);
    send_word(12'd2000, 2'd1);
    drain();
    write_reg(REG_SUP, 32'd0);
    send_word(12'd1000, 2'd2);
    send_word(12'd1, 2'd3);
    drain();
    // huge divider: resistance clamp; full-scale mv at max
    write_reg(REG_FS, 32'hFFFF_FFFF);
    write_reg(REG_DIV, 32'hFFFF_FFFF);
    write_reg(REG_SUP, 32'hFFFF_FFFF);
    send_word(12'd4094, 2'd0);
    send_word(12'd100, 2'd1);
    drain();
    // temperature saturation both ways
    write_reg(REG_QUAD, 32'h7FFF_FFFF);
    write_reg(REG_LIN, 32'h7FFF_FFFF);
    write_reg(REG_CONST, 32'h007F_FFFF);
    send_word(12'd3000, 2'd2);
    send_word(12'd1, 2'd3);
    drain();
    write_reg(REG_QUAD, 32'h8000_0000);
    write_reg(REG_LIN, 32'h8000_0000);
    write_reg(REG_CONST, 32'h0080_0000);
    send_word(12'd3000, 2'd0);
    send_word(12'd1, 2'd1);
    drain();

    // random phases with random register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_FS, $urandom);
      write_reg(REG_DIV, ph[0] ? $urandom_range(200000) : $urandom);
      write_reg(REG_SUP, ph == 5 ? 32'hFFFF : $urandom);
      write_reg(REG_QUAD, ph < 2 ? $urandom_range(2000000) : $urandom);
      write_reg(REG_LIN, ph < 2 ? -$urandom_range(400000) : $urandom);
      write_reg(REG_CONST, $urandom);
      if (ph == 2) begin
        calm = 1'b1;
        random_words(120);
        calm = 1'b0;
      end
      if (ph == 3) begin
        // long output stall while input keeps offering
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(negedge clk);
            hold_off = 1'b0;
          end
          random_words(100);
        join
      end
      random_words(200);
      drain();
    end

    // reset coefficients again for realistic temperatures
    write_reg(REG_FS, 32'd3300);
    write_reg(REG_DIV, 32'd10000);
    write_reg(REG_SUP, 32'd3300);
    write_reg(REG_QUAD, 32'd607874);
    write_reg(REG_LIN, -32'sd168198);
    write_reg(REG_CONST, 32'd11219);
    random_words(400);
    drain();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/thac_pkg.sv
rtl/thermistor_adc_to_celsius.sv
bench/thac_checker.sv
bench/thermistor_adc_to_celsius_tb.sv
